/* sv/ppd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-to-plane distance package
// Shared widths, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package ppd_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int COORD_WIDTH = 32;

   localparam int DIST_W    = COORD_WIDTH - 1;
   localparam int PROD_W    = 2 * COORD_WIDTH;
   localparam int SUM_W     = 2 * COORD_WIDTH + 2;
   localparam int MAG_W     = 2 * COORD_WIDTH + 1;
   localparam int NSQ_W     = 2 * COORD_WIDTH;
   localparam int BIT_CNT_W = $clog2(COORD_WIDTH);
   localparam int CSR_IDX_W = 3;

   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   localparam logic [CSR_IDX_W-1:0] REG_UNIT_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PLANE_A   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PLANE_B   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PLANE_C   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET    = 3'd4;

   typedef enum logic [2:0] {
      NORM_IDLE   = 3'b001,
      NORM_SQUARE = 3'b010,
      NORM_ROOT   = 3'b100
   } norm_state_type;

   // One entry of the normalizing divider pipeline.
   typedef struct packed {
      logic              valid;
      logic              done;
      logic              positive;
      logic              zero_normal;
      logic [MAG_W-1:0]  rem;
      logic [DIST_W-1:0] quot;
   } div_stage_type;

endpackage

/* sv/ppd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-to-plane distance channels
// Point, result and register-write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface ppd_req_if import ppd_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] point_x;
   logic signed [COORD_WIDTH-1:0] point_y;
   logic signed [COORD_WIDTH-1:0] point_z;
   modport source (output valid, point_x, point_y, point_z, input ready);
   modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface ppd_rsp_if import ppd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DIST_W-1:0] distance;
   logic              positive_side;
   logic              zero_normal;
   modport source (output valid, distance, positive_side, zero_normal, input ready);
   modport sink   (input valid, distance, positive_side, zero_normal, output ready);
endinterface

interface ppd_csr_if import ppd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_IDX_W-1:0]   index;
   logic [COORD_WIDTH-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* sv/point_plane_distance.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-to-plane distance
// Pipelined plane evaluation with a normalizing divider per point.
// ----------------------------------------------------------------------------
// The block takes one signed Q16.16 point per transfer and returns one result
// per point: the distance to the plane A*x + B*y + C*z + D = 0 (or |s| in
// unit-normal mode), a positive-side flag and a zero-normal flag. Points are
// accepted every cycle while the first stage has room and the normal-length
// computation is idle. The pipeline has three arithmetic stages followed by
// one divider stage per quotient bit. Each stage advances whenever its
// successor has room, so a stalled result side only holds the items that are
// actually blocked. Writing plane_a, plane_b or plane_c starts a normal-length
// computation: three squaring steps, then one root bit per cycle, on a shared
// multiplier. The same computation runs after reset. No point is accepted
// while it runs; register writes are always taken.
// ----------------------------------------------------------------------------
module point_plane_distance
   import ppd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   ppd_req_if.sink   req,
   ppd_rsp_if.source rsp,
   ppd_csr_if.sink   csr
);

   localparam int NUM_DIV = COORD_WIDTH;       // stage 2 plus one per quotient bit
   localparam int NUM_STG = NUM_DIV + 2;

   // Configuration registers.
   logic                          unit_mode_ff;
   logic signed [COORD_WIDTH-1:0] plane_a_ff, plane_b_ff, plane_c_ff, offset_ff;

   // Normal length sequencer.
   norm_state_type                norm_state_ff;
   logic [BIT_CNT_W-1:0]          bit_cnt_ff;
   logic [NSQ_W-1:0]              nsq_ff;
   logic [COORD_WIDTH-1:0]        root_ff;
   logic [COORD_WIDTH-1:0]        norm_ff;
   logic signed [COORD_WIDTH:0]   mul_op;
   logic signed [2*COORD_WIDTH+1:0] mul_full;
   logic [NSQ_W-1:0]              mul_prod;
   logic [COORD_WIDTH-1:0]        root_cand;
   logic                          csr_write;

   // Pipeline.
   logic [NUM_STG-1:0]            stage_en;
   logic [NUM_STG-1:0]            stage_valid;
   logic                          s0_valid_ff;
   logic signed [PROD_W-1:0]      s0_ax_ff, s0_by_ff, s0_cz_ff;
   logic signed [COORD_WIDTH-1:0] s0_d_ff;
   logic                          s1_valid_ff;
   logic signed [SUM_W-1:0]       s1_sum_ff;
   div_stage_type                 div_ff [NUM_DIV];
   div_stage_type                 div_in [NUM_DIV];

   logic signed [SUM_W-1:0]       sum_in;
   logic [SUM_W-1:0]              abs_sum;
   logic [MAG_W-1:0]              mag;
   logic                          in_transfer;

   // ---------------------------------------------------------------------
   // Register port. Writes complete in the cycle they are offered.
   // ---------------------------------------------------------------------
   assign csr.ready = 1'b1;
   assign csr_write = csr.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_mode_ff <= 1'b0;
         plane_a_ff   <= '0;
         plane_b_ff   <= '0;
         plane_c_ff   <= COORD_WIDTH'(1) <<< FRAC_BITS;
         offset_ff    <= '0;
      end else if (csr_write) begin
         case (csr.index)
            REG_UNIT_MODE: unit_mode_ff <= csr.data[0];
            REG_PLANE_A:   plane_a_ff   <= csr.data;
            REG_PLANE_B:   plane_b_ff   <= csr.data;
            REG_PLANE_C:   plane_c_ff   <= csr.data;
            REG_OFFSET:    offset_ff    <= csr.data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Normal length: nsq = A^2 + B^2 + C^2, then a bit-by-bit integer root.
   // Both phases share one multiplier.
   // ---------------------------------------------------------------------
   assign root_cand = root_ff | (COORD_WIDTH'(1) << bit_cnt_ff);

   always_comb begin
      if (norm_state_ff == NORM_ROOT) begin
         mul_op = $signed({1'b0, root_cand});
      end else begin
         case (bit_cnt_ff[1:0])
            2'd0:    mul_op = {plane_a_ff[COORD_WIDTH-1], plane_a_ff};
            2'd1:    mul_op = {plane_b_ff[COORD_WIDTH-1], plane_b_ff};
            default: mul_op = {plane_c_ff[COORD_WIDTH-1], plane_c_ff};
         endcase
      end
      mul_full = mul_op * mul_op;
      mul_prod = mul_full[NSQ_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         norm_state_ff <= NORM_SQUARE;
         bit_cnt_ff    <= '0;
         nsq_ff        <= '0;
         root_ff       <= '0;
         norm_ff       <= '0;
      end else if (csr_write && (csr.index == REG_PLANE_A || csr.index == REG_PLANE_B
                                 || csr.index == REG_PLANE_C)) begin
         norm_state_ff <= NORM_SQUARE;
         bit_cnt_ff    <= '0;
         nsq_ff        <= '0;
         root_ff       <= '0;
      end else begin
         case (norm_state_ff)
            NORM_SQUARE: begin
               nsq_ff <= nsq_ff + mul_prod;
               if (bit_cnt_ff == BIT_CNT_W'(2)) begin
                  norm_state_ff <= NORM_ROOT;
                  bit_cnt_ff    <= BIT_CNT_W'(COORD_WIDTH - 1);
               end else begin
                  bit_cnt_ff <= bit_cnt_ff + 1'b1;
               end
            end
            NORM_ROOT: begin
               if (mul_prod <= nsq_ff) begin
                  root_ff <= root_cand;
               end
               if (bit_cnt_ff == '0) begin
                  norm_state_ff <= NORM_IDLE;
                  norm_ff       <= (mul_prod <= nsq_ff) ? root_cand : root_ff;
               end else begin
                  bit_cnt_ff <= bit_cnt_ff - 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Flow control: a stage advances when it is empty or its successor moves.
   // ---------------------------------------------------------------------
   always_comb begin
      stage_valid[0] = s0_valid_ff;
      stage_valid[1] = s1_valid_ff;
      for (int k = 0; k < NUM_DIV; k++) begin
         stage_valid[k+2] = div_ff[k].valid;
      end
      stage_en[NUM_STG-1] = !stage_valid[NUM_STG-1] || rsp.ready;
      for (int k = NUM_STG - 2; k >= 0; k--) begin
         stage_en[k] = !stage_valid[k] || stage_en[k+1];
      end
   end

   assign req.ready   = stage_en[0] && (norm_state_ff == NORM_IDLE);
   assign in_transfer = req.valid && req.ready;

   // Stage 0: the three products.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (stage_en[0]) begin
         s0_valid_ff <= in_transfer;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s0_ax_ff <= plane_a_ff * req.point_x;
         s0_by_ff <= plane_b_ff * req.point_y;
         s0_cz_ff <= plane_c_ff * req.point_z;
         s0_d_ff  <= offset_ff;
      end
   end

   // Stage 1: exact plane value with 2F fraction bits.
   assign sum_in = SUM_W'(s0_ax_ff) + SUM_W'(s0_by_ff) + SUM_W'(s0_cz_ff)
                 + (SUM_W'(s0_d_ff) <<< FRAC_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (stage_en[1]) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         s1_sum_ff <= sum_in;
      end
   end

   // Stage 2 prepares the divider entry; the unit-normal, zero-normal and
   // saturated cases are finished here and ride through the divider.
   assign abs_sum = s1_sum_ff[SUM_W-1] ? SUM_W'(-s1_sum_ff) : SUM_W'(s1_sum_ff);
   assign mag     = abs_sum[MAG_W-1:0];

   always_comb begin
      div_in[0].valid       = s1_valid_ff;
      div_in[0].positive    = !s1_sum_ff[SUM_W-1] && (s1_sum_ff != '0);
      div_in[0].zero_normal = 1'b0;
      div_in[0].rem         = mag;
      div_in[0].quot        = '0;
      div_in[0].done        = 1'b0;
      if (unit_mode_ff) begin
         div_in[0].done = 1'b1;
         div_in[0].quot = ((mag >> (DIST_W + FRAC_BITS)) != '0)
                        ? DIST_MAX : mag[DIST_W+FRAC_BITS-1:FRAC_BITS];
      end else if (norm_ff == '0) begin
         div_in[0].done        = 1'b1;
         div_in[0].zero_normal = 1'b1;
         div_in[0].quot        = DIST_MAX;
      end else if (mag >= (MAG_W'(norm_ff) << DIST_W)) begin
         div_in[0].done = 1'b1;
         div_in[0].quot = DIST_MAX;
      end
      // Divider stage j resolves quotient bit COORD_WIDTH-1-j.
      for (int j = 1; j < NUM_DIV; j++) begin
         div_in[j] = div_ff[j-1];
         if (!div_ff[j-1].done
             && div_ff[j-1].rem >= (MAG_W'(norm_ff) << (COORD_WIDTH - 1 - j))) begin
            div_in[j].rem = div_ff[j-1].rem - (MAG_W'(norm_ff) << (COORD_WIDTH - 1 - j));
            div_in[j].quot[COORD_WIDTH-1-j] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < NUM_DIV; j++) begin
         if (reset) begin
            div_ff[j].valid <= 1'b0;
         end else if (stage_en[j+2]) begin
            div_ff[j] <= div_in[j];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result side: the last divider stage is the output register.
   // ---------------------------------------------------------------------
   assign rsp.valid         = div_ff[NUM_DIV-1].valid;
   assign rsp.distance      = div_ff[NUM_DIV-1].quot;
   assign rsp.positive_side = div_ff[NUM_DIV-1].positive;
   assign rsp.zero_normal   = div_ff[NUM_DIV-1].zero_normal;

endmodule

/* sv/ppd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-to-plane distance checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module ppd_checker
   import ppd_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DIST_W-1:0] rsp_distance,
   input logic              rsp_positive_side,
   input logic              rsp_zero_normal
);

   // A result that waits keeps being offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before transfer");

   // A waiting result keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_distance) && $stable(rsp_positive_side)
                                  && $stable(rsp_zero_normal))
      else $error("result changed while stalled");

   // A zero normal always saturates the distance.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_normal |-> rsp_distance == DIST_MAX)
      else $error("zero normal without saturated distance");

   // No result can emerge right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind point_plane_distance ppd_checker u_ppd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp.valid),
   .rsp_ready         (rsp.ready),
   .rsp_distance      (rsp.distance),
   .rsp_positive_side (rsp.positive_side),
   .rsp_zero_normal   (rsp.zero_normal)
);
